// File: hdl/tsr_pkg.sv
package tsr_pkg;

  // Fixed point format of the angle registers
  localparam int FRAC_BITS = 14;
  localparam int MAX_SIDE  = 256;
  localparam int HALF_MAX  = MAX_SIDE / 2;
  localparam int NUM_W     = 32;

  // Configuration register map
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_WIDTH  = 3'd0,
    REG_HALF_HEIGHT = 3'd1,
    REG_SIN_ANGLE   = 3'd2,
    REG_TAN_HALF    = 3'd3,
    REG_MIRROR      = 3'd4
  } reg_idx_t;

  // Coordinate and product widths along the shear chain
  typedef logic signed [8:0]  c0_t;   // centered coordinate, -128..255
  typedef logic signed [24:0] p1_t;   // tan * y0
  typedef logic signed [10:0] c1_t;   // x1, -638..765
  typedef logic signed [26:0] p2_t;   // sin * x1
  typedef logic signed [11:0] c2_t;   // y1, about +-1785
  typedef logic signed [27:0] p3_t;   // tan * y1
  typedef logic signed [13:0] c3_t;   // x2, about +-4335

  // Live configuration, half sides already clamped
  typedef struct packed {
    logic [7:0]         hw;
    logic [7:0]         hh;
    logic signed [15:0] sin_a;
    logic signed [15:0] tan_h;
    logic               mirror;
  } cfg_t;

  // Word handed from the front half to the back half
  typedef struct packed {
    c0_t         y0;
    c1_t         x1;
    p2_t         p2;
    logic [31:0] color;
  } mid_t;

  // Drop the fraction bits, rounding toward zero
  function automatic logic signed [NUM_W-1:0] trunc_frac(input logic signed [NUM_W-1:0] num);
    logic signed [NUM_W-1:0] q;
    q = num >>> FRAC_BITS;
    if (num[NUM_W-1] && (num[FRAC_BITS-1:0] != '0)) begin
      q = q + NUM_W'(1);
    end
    return q;
  endfunction

endpackage

// File: hdl/tsr_front.sv
module tsr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  tsr_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          src_row,
  input  logic [7:0]          src_col,
  input  logic [31:0]         src_color,
  output logic                mid_valid,
  input  logic                mid_ready,
  output tsr_pkg::mid_t       mid
);
  import tsr_pkg::*;

  logic        v1_r, v2_r;
  logic        rdy1, rdy2;
  c0_t         x0_c, y0_c;
  p1_t         p1_c;
  c0_t         x0_r, y0_r;
  p1_t         p1_r;
  logic [31:0] color1_r;
  logic signed [NUM_W-1:0] num1;
  c1_t         x1_c;
  p2_t         p2_c;
  mid_t        mid_r;

  // A slot takes a new word when it is empty or its word moves on
  assign rdy2     = !v2_r || mid_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // Stage 1: center on the sprite middle, first shear product
  assign x0_c = c0_t'({1'b0, src_col}) - c0_t'({1'b0, cfg.hw});
  assign y0_c = c0_t'({1'b0, src_row}) - c0_t'({1'b0, cfg.hh});
  assign p1_c = p1_t'(cfg.tan_h) * p1_t'(y0_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      x0_r     <= x0_c;
      y0_r     <= y0_c;
      p1_r     <= p1_c;
      color1_r <= src_color;
    end
  end

  // Stage 2: x1 = trunc(x0 - T*y0), then S*x1
  assign num1 = (NUM_W'(x0_r) <<< FRAC_BITS) - NUM_W'(p1_r);
  assign x1_c = c1_t'(trunc_frac(num1));
  assign p2_c = p2_t'(cfg.sin_a) * p2_t'(x1_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      mid_r.y0    <= y0_r;
      mid_r.x1    <= x1_c;
      mid_r.p2    <= p2_c;
      mid_r.color <= color1_r;
    end
  end

  assign mid_valid = v2_r;
  assign mid       = mid_r;

endmodule

// File: hdl/tsr_back.sv
module tsr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  tsr_pkg::cfg_t       cfg,
  input  logic                mid_valid,
  output logic                mid_ready,
  input  tsr_pkg::mid_t       mid,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          dst_row,
  output logic [7:0]          dst_col,
  output logic [31:0]         dst_color,
  output logic                write_enable
);
  import tsr_pkg::*;

  logic        v3_r, out_valid_r;
  logic        rdy3, rdy4;
  logic signed [NUM_W-1:0] num2, num3;
  c2_t         y1_c;
  p3_t         p3_c;
  c1_t         x1_r;
  c2_t         y1_r;
  p3_t         p3_r;
  logic [31:0] color3_r;
  c3_t         x2_c;
  c2_t         hh_s;
  c3_t         hw_s;
  logic        we_c;
  c2_t         row_c;
  c3_t         col_c;
  logic [7:0]  row_r, col_r;
  logic [31:0] color_r;
  logic        we_r;

  assign rdy4      = !out_valid_r || out_ready;
  assign rdy3      = !v3_r || rdy4;
  assign mid_ready = rdy3;

  // Stage 3: y1 = trunc(y0 + S*x1), then T*y1
  assign num2 = (NUM_W'(mid.y0) <<< FRAC_BITS) + NUM_W'(mid.p2);
  assign y1_c = c2_t'(trunc_frac(num2));
  assign p3_c = p3_t'(cfg.tan_h) * p3_t'(y1_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && mid_valid) begin
      x1_r     <= mid.x1;
      y1_r     <= y1_c;
      p3_r     <= p3_c;
      color3_r <= mid.color;
    end
  end

  // Stage 4: x2 = trunc(x1 - T*y1), bounds test and mirroring
  assign num3 = (NUM_W'(x1_r) <<< FRAC_BITS) - NUM_W'(p3_r);
  assign x2_c = c3_t'(trunc_frac(num3));
  assign hh_s = c2_t'({1'b0, cfg.hh});
  assign hw_s = c3_t'({1'b0, cfg.hw});

  assign we_c = (color3_r[23:0] != 24'd0) &&
                (y1_r >= -hh_s) && (y1_r < hh_s) &&
                (x2_c >= -hw_s) && (x2_c < hw_s);

  // Mirrored position is 2h-1-(p+h) = h-1-p
  always_comb begin
    if (cfg.mirror) begin
      row_c = hh_s - c2_t'(1) - y1_r;
      col_c = hw_s - c3_t'(1) - x2_c;
    end else begin
      row_c = y1_r + hh_s;
      col_c = x2_c + hw_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy4) begin
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      row_r   <= we_c ? row_c[7:0] : 8'd0;
      col_r   <= we_c ? col_c[7:0] : 8'd0;
      color_r <= color3_r;
      we_r    <= we_c;
    end
  end

  assign out_valid    = out_valid_r;
  assign dst_row      = row_r;
  assign dst_col      = col_r;
  assign dst_color    = color_r;
  assign write_enable = we_r;

endmodule

// File: hdl/three_shear_sprite_rotation.sv
// Three-shear sprite rotation.
// Input channel (in_valid/in_ready): one source pixel per word, its row,
// column and packed ARGB color. Result channel (out_valid/out_ready): one
// word per pixel with destination row/column, the unchanged color and a
// write flag; row and column read zero when the flag is low.
// Configuration: cfg_we writes cfg_wdata into register cfg_index
// (half width, half height, sine, half-angle tangent, mirror); indexes
// past the map are ignored. Write only while the pipe is empty.
// Four registered stages lie from input accept to out_valid. One pixel
// per cycle while out_ready is high: each stage takes a new word unless
// stalled (first three: a shear product each; the last: the bounds test).
// Reset clears all stage valid bits and restores the register defaults
// (16x16 half sides, zero angle, no mirror).
// A stalled receiver holds the output word; earlier stages keep filling
// empty slots, and in_ready drops once every stage holds a word.
module three_shear_sprite_rotation (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_src_row,
  input  logic [7:0]                     in_src_col,
  input  logic [31:0]                    in_src_color,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_dst_row,
  output logic [7:0]                     out_dst_col,
  output logic [31:0]                    out_dst_color,
  output logic                           out_write_enable
);
  import tsr_pkg::*;

  logic [7:0]         half_width_r;
  logic [7:0]         half_height_r;
  logic signed [15:0] sin_angle_r;
  logic signed [15:0] tan_half_r;
  logic               mirror_r;
  cfg_t               cfg;
  logic               mid_valid, mid_ready;
  mid_t               mid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_width_r  <= 8'd16;
      half_height_r <= 8'd16;
      sin_angle_r   <= '0;
      tan_half_r    <= '0;
      mirror_r      <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_HALF_WIDTH:  half_width_r  <= cfg_wdata[7:0];
        REG_HALF_HEIGHT: half_height_r <= cfg_wdata[7:0];
        REG_SIN_ANGLE:   sin_angle_r   <= cfg_wdata;
        REG_TAN_HALF:    tan_half_r    <= cfg_wdata;
        REG_MIRROR:      mirror_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Half sides limited so a destination fits the frame
  assign cfg.hw     = (32'(half_width_r) > HALF_MAX) ? 8'(HALF_MAX) : half_width_r;
  assign cfg.hh     = (32'(half_height_r) > HALF_MAX) ? 8'(HALF_MAX) : half_height_r;
  assign cfg.sin_a  = sin_angle_r;
  assign cfg.tan_h  = tan_half_r;
  assign cfg.mirror = mirror_r;

  tsr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .src_row   (in_src_row),
    .src_col   (in_src_col),
    .src_color (in_src_color),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid       (mid)
  );

  tsr_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .mid_valid    (mid_valid),
    .mid_ready    (mid_ready),
    .mid          (mid),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .dst_row      (out_dst_row),
    .dst_col      (out_dst_col),
    .dst_color    (out_dst_color),
    .write_enable (out_write_enable)
  );

endmodule

// File: tb/tsr_placement_checker.sv
module tsr_placement_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [7:0]                     in_src_row,
  input  logic [7:0]                     in_src_col,
  input  logic [31:0]                    in_src_color,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [7:0]                     out_dst_row,
  input  logic [7:0]                     out_dst_col,
  input  logic [31:0]                    out_dst_color,
  input  logic                           out_write_enable,
  output int                             error_count,
  output int                             pending_count,
  output int                             checked_count,
  output int                             landed_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import tsr_pkg::*;

  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic [7:0]  row;
    logic [7:0]  col;
    logic [31:0] color;
    logic        we;
  } placement_t;

  // Shadow of the register file
  logic [7:0]         half_w;
  logic [7:0]         half_h;
  logic signed [15:0] sin_q;
  logic signed [15:0] tan_q;
  logic               mirror_on;

  placement_t placement_q[$];
  int         errs;
  int         checked;
  int         landed;

  // One shear step: base +/- coef*val in Q.FRAC_BITS, truncated toward zero
  function automatic longint shear_trunc(longint base, longint coef, longint val, bit negate);
    longint num;
    num = base * (longint'(1) << FRAC_BITS);
    num = negate ? num - coef * val : num + coef * val;
    return num / (longint'(1) << FRAC_BITS);
  endfunction

  // Destination of one source pixel under the current registers
  function automatic placement_t rotate_pixel(logic [7:0] row, logic [7:0] col,
                                              logic [31:0] color);
    longint hw, hh, x0, y0, x1, y1, x2, drow, dcol;
    placement_t p;
    hw = (half_w > HALF_MAX) ? longint'(HALF_MAX) : longint'(half_w);
    hh = (half_h > HALF_MAX) ? longint'(HALF_MAX) : longint'(half_h);
    x0 = longint'(col) - hw;
    y0 = longint'(row) - hh;
    x1 = shear_trunc(x0, longint'(tan_q), y0, 1'b1);
    y1 = shear_trunc(y0, longint'(sin_q), x1, 1'b0);
    x2 = shear_trunc(x1, longint'(tan_q), y1, 1'b1);
    p.color = color;
    p.we = (color[23:0] != 24'h0) && (y1 >= -hh) && (y1 < hh) && (x2 >= -hw) && (x2 < hw);
    drow = 0;
    dcol = 0;
    if (p.we) begin
      drow = y1 + hh;
      dcol = x2 + hw;
      if (mirror_on) begin
        drow = 2 * hh - 1 - drow;
        dcol = 2 * hw - 1 - dcol;
      end
    end
    p.row = 8'(drow);
    p.col = 8'(dcol);
    return p;
  endfunction

  task automatic report_mismatch(input string what);
    errs++;
    if (errs <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  always @(posedge clk) begin : watch
    placement_t want;
    if (!rst_n) begin
      half_w    = 8'd16;
      half_h    = 8'd16;
      sin_q     = '0;
      tan_q     = '0;
      mirror_on = 1'b0;
      placement_q.delete();
    end else begin
      // register writes, unknown indexes fall through
      if (cfg_we) begin
        case (cfg_index)
          REG_HALF_WIDTH:  half_w    = cfg_wdata[7:0];
          REG_HALF_HEIGHT: half_h    = cfg_wdata[7:0];
          REG_SIN_ANGLE:   sin_q     = cfg_wdata;
          REG_TAN_HALF:    tan_q     = cfg_wdata;
          REG_MIRROR:      mirror_on = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        placement_q.insert(placement_q.size(),
                           rotate_pixel(in_src_row, in_src_col, in_src_color));
      end
      // result word against the oldest prediction
      if (out_valid && out_ready) begin
        if (placement_q.size() == 0) begin
          report_mismatch("result word with nothing outstanding");
        end else begin
          want = placement_q.pop_front();
          checked++;
          if (want.we) landed++;
          if (out_write_enable !== want.we)
            report_mismatch($sformatf("write_enable %b, want %b (color %h)",
                                      out_write_enable, want.we, want.color));
          if (out_dst_row !== want.row)
            report_mismatch($sformatf("dst_row %0d, want %0d (color %h)",
                                      out_dst_row, want.row, want.color));
          if (out_dst_col !== want.col)
            report_mismatch($sformatf("dst_col %0d, want %0d (color %h)",
                                      out_dst_col, want.col, want.color));
          if (out_dst_color !== want.color)
            report_mismatch($sformatf("dst_color %h, want %h", out_dst_color, want.color));
        end
      end
    end
    pending_count <= placement_q.size();
    error_count   <= errs;
    checked_count <= checked;
    landed_count  <= landed;
  end

endmodule

// File: tb/tb_three_shear_sprite_rotation.sv
module tb_three_shear_sprite_rotation;
  timeunit 1ns;
  timeprecision 1ps;
  import tsr_pkg::*;

  localparam int          CYCLE_LIMIT  = 1_500_000;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          RANDOM_PHASES = 14;
  localparam int          PHASE_PIXELS  = 125;
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_HI = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            in_src_row;
  logic [7:0]            in_src_col;
  logic [31:0]           in_src_color;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            out_dst_row;
  logic [7:0]            out_dst_col;
  logic [31:0]           out_dst_color;
  logic                  out_write_enable;

  int          mismatches;
  int          pending;
  int          checked;
  int          landed;
  int          idle_pct;
  int          ready_hold;
  int          pixels_sent;
  int          settings_used;
  int unsigned cycle_count = 0;
  logic [7:0]  cur_hw;
  logic [7:0]  cur_hh;

  three_shear_sprite_rotation dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_src_row       (in_src_row),
    .in_src_col       (in_src_col),
    .in_src_color     (in_src_color),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_dst_row      (out_dst_row),
    .out_dst_col      (out_dst_col),
    .out_dst_color    (out_dst_color),
    .out_write_enable (out_write_enable)
  );

  tsr_placement_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_src_row       (in_src_row),
    .in_src_col       (in_src_col),
    .in_src_color     (in_src_color),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_dst_row      (out_dst_row),
    .out_dst_col      (out_dst_col),
    .out_dst_color    (out_dst_color),
    .out_write_enable (out_write_enable),
    .error_count      (mismatches),
    .pending_count    (pending),
    .checked_count    (checked),
    .landed_count     (landed)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r = $urandom_range(99);
    if (r < 80) return $urandom_range(3, 1);
    if (r < 95) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic int idle_gap();
    if ($urandom_range(99) < idle_pct) return pick_gap();
    return 0;
  endfunction

  // Receiver stalls
  always @(posedge clk) begin : ready_gen
    int gap;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!out_ready) begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(15);
    end else begin
      gap = idle_gap();
      if (gap > 0) begin
        out_ready  <= 1'b0;
        ready_hold <= gap - 1;
      end
    end
  end

  // One pixel word; valid stays up into the next call when no gap follows
  task automatic send_pixel(input logic [7:0] row, input logic [7:0] col,
                            input logic [31:0] color);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_src_row   <= row;
    in_src_col   <= col;
    in_src_color <= color;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
  endtask

  // Pipe empty before any register write
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_geometry(input logic [7:0] hw, input logic [7:0] hh,
                              input logic [15:0] sin_a, input logic [15:0] tan_h,
                              input logic mirror);
    drain();
    write_reg(REG_HALF_WIDTH, 16'(hw));
    write_reg(REG_HALF_HEIGHT, 16'(hh));
    write_reg(REG_SIN_ANGLE, sin_a);
    write_reg(REG_TAN_HALF, tan_h);
    write_reg(REG_MIRROR, 16'(mirror));
    cur_hw = hw;
    cur_hh = hh;
    settings_used++;
  endtask

  function automatic logic [7:0] pick_half();
    int r = $urandom_range(99);
    if (r < 12) begin
      case ($urandom_range(4))
        0:       return 8'd0;
        1:       return 8'd1;
        2:       return 8'd128;
        3:       return 8'd129;
        default: return 8'd255;
      endcase
    end
    if (r < 60) return 8'($urandom_range(16, 1));
    return 8'($urandom_range(128, 1));
  endfunction

  // Coordinate inside the sprite span, anywhere when the span is empty
  function automatic logic [7:0] pick_coord(input logic [7:0] half);
    int span;
    span = (half > HALF_MAX) ? MAX_SIDE : 2 * half;
    if (span == 0) return 8'($urandom);
    return 8'($urandom_range(span - 1));
  endfunction

  function automatic logic [31:0] pick_color();
    int r = $urandom_range(99);
    if (r < 15) return {8'($urandom), 24'h0};
    if (r < 20) return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0001;
    return $urandom;
  endfunction

  task automatic random_phase(input int phase);
    int    r;
    int    t_fix;
    real   t_real;
    logic [15:0] sin_a;
    logic [15:0] tan_h;
    logic [7:0]  row;
    logic [7:0]  col;
    int    idle_levels[4];
    idle_levels = '{0, 15, 40, 75};
    // angle: mostly a consistent sine/tangent pair, some independent, some raw
    r = $urandom_range(99);
    if (r < 60) begin
      t_fix  = int'($urandom_range(32768)) - 16384;
      t_real = t_fix / 16384.0;
      tan_h  = 16'(t_fix);
      sin_a  = 16'($rtoi(2.0 * t_real / (1.0 + t_real * t_real) * 16384.0));
    end else if (r < 90) begin
      tan_h = 16'(int'($urandom_range(32768)) - 16384);
      sin_a = 16'(int'($urandom_range(32768)) - 16384);
    end else begin
      tan_h = 16'($urandom);
      sin_a = 16'($urandom);
    end
    set_geometry(pick_half(), pick_half(), sin_a, tan_h, 1'($urandom_range(1)));
    if ($urandom_range(3) == 0)
      write_reg(IDX_UNUSED_LO + 3'($urandom_range(2)), 16'($urandom));
    idle_pct = idle_levels[phase % 4];
    for (int i = 0; i < PHASE_PIXELS; i++) begin
      if ($urandom_range(99) < 85) begin
        row = pick_coord(cur_hh);
        col = pick_coord(cur_hw);
      end else begin
        row = 8'($urandom);
        col = 8'($urandom);
      end
      send_pixel(row, col, pick_color());
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_src_row    = '0;
    in_src_col    = '0;
    in_src_color  = '0;
    idle_pct      = 20;
    pixels_sent   = 0;
    settings_used = 1;
    cur_hw        = 8'd16;
    cur_hh        = 8'd16;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset geometry: corners, far outside, colorless with alpha, black
    send_pixel(8'd0, 8'd0, 32'hFFFF_FFFF);
    send_pixel(8'd31, 8'd31, 32'h00FF_FFFF);
    send_pixel(8'd0, 8'd31, 32'h1200_0001);
    send_pixel(8'd31, 8'd0, 32'hFF00_0000);
    send_pixel(8'd255, 8'd255, 32'h8080_8080);
    send_pixel(8'd16, 8'd16, 32'h0000_0000);
    send_pixel(8'd32, 8'd5, 32'h0001_0000);

    // writes past the register map must leave the geometry alone
    drain();
    write_reg(IDX_UNUSED_LO, 16'hFFFF);
    write_reg(IDX_UNUSED_HI, 16'hFFFF);
    send_pixel(8'd0, 8'd0, 32'h0000_FF00);

    // oversized half sides, full positive angle, mirrored
    set_geometry(8'd255, 8'd255, 16'sd16384, 16'sd16384, 1'b1);
    send_pixel(8'd0, 8'd0, 32'h00AB_CDEF);
    send_pixel(8'd255, 8'd255, 32'hFFFF_FFFF);
    send_pixel(8'd128, 8'd128, 32'h0000_0001);
    send_pixel(8'd255, 8'd0, 32'h7F80_0000);
    send_pixel(8'd0, 8'd255, 32'h0101_0101);

    // two-pixel-wide sprite, full negative angle
    set_geometry(8'd1, 8'd128, -16'sd16384, -16'sd16384, 1'b0);
    send_pixel(8'd0, 8'd0, 32'h00FF_0000);
    send_pixel(8'd255, 8'd1, 32'hFFFF_FFFF);
    send_pixel(8'd1, 8'd255, 32'h0000_00FF);
    send_pixel(8'd128, 8'd0, 32'h5A5A_5A5A);

    // zero half sides, register extremes beyond the trig range
    set_geometry(8'd0, 8'd0, 16'h8000, 16'h7FFF, 1'b1);
    send_pixel(8'd0, 8'd0, 32'hFFFF_FFFF);
    send_pixel(8'd255, 8'd255, 32'h00FF_FFFF);
    send_pixel(8'd128, 8'd128, 32'h8000_0001);

    // flat sprite at 45 degrees, mirrored
    set_geometry(8'd128, 8'd1, 16'sd11585, 16'sd6786, 1'b1);
    send_pixel(8'd0, 8'd0, 32'h0000_0100);
    send_pixel(8'd1, 8'd255, 32'h0000_0100);
    send_pixel(8'd2, 8'd128, 32'h0000_0100);
    send_pixel(8'd0, 8'd128, 32'h0000_0100);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_phase(p);
    end

    drain();
    $display("Sent %0d pixels under %0d register settings with mixed idle rates.",
             pixels_sent, settings_used);
    $display("Checked %0d result words, %0d of them landing inside the sprite.",
             checked, landed);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: three_shear_sprite_rotation.f
hdl/tsr_pkg.sv
hdl/tsr_front.sv
hdl/tsr_back.sv
hdl/three_shear_sprite_rotation.sv
tb/tsr_placement_checker.sv
tb/tb_three_shear_sprite_rotation.sv
